>>> hw/rtl/lsra_pkg.sv
`timescale 1ns / 1ps

package lsra_pkg;

  localparam int NUM_REGS  = 7;
  localparam int ID_WIDTH  = 10;
  localparam int POS_WIDTH = 16;
  localparam int REG_BASE  = 4;

  localparam int END_W  = POS_WIDTH + 1;
  localparam int IDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CNT_W  = $clog2(NUM_REGS + 1);
  localparam int AREG_W = 4;

  localparam int IN_FIELDS_W  = ID_WIDTH + POS_WIDTH + END_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 1 + AREG_W + 1 + 1 + ID_WIDTH + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

>>> hw/rtl/linear_scan_register_allocator.sv
`timescale 1ns / 1ps

// S_IDLE takes an input beat, S_EXPIRE frees the active intervals that end before its start,
// S_ALLOC takes the lowest free register, evicts or spills, S_INSERT moves entries for the
// sorted insert, S_OUT loads the result; one end comparator serves expiry, spill check and
// insert; expired plus moved entries never exceed NUM_REGS; a spilled newcomer skips the
// insert; a held result register adds stalls; the next input beat waits for S_IDLE again
// reset: rst_n low clears the active list, frees every register and the failure flag

module linear_scan_register_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // interval_id, start_pos, end_pos, zero pad
  input  logic [lsra_pkg::IN_DATA_W-1:0]  in_tdata,
  // new_pass
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // got_register, assigned_reg, spilled_self, evicted_valid, evicted_id, pass_failed, zero pad
  output logic [lsra_pkg::OUT_DATA_W-1:0] out_tdata
);
  import lsra_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXPIRE,
    S_ALLOC,
    S_INSERT,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [NUM_REGS-1:0] free_r, free_nxt;
  logic                failed_r, failed_nxt;

  // active list, sorted by end; entries from index cnt_r up are don't care
  logic signed [END_W-1:0] ent_end_r [NUM_REGS];
  logic [ID_WIDTH-1:0]     ent_id_r  [NUM_REGS];
  logic [IDX_W-1:0]        ent_reg_r [NUM_REGS];

  logic [ID_WIDTH-1:0]     cur_id_r, cur_id_nxt;
  logic [POS_WIDTH-1:0]    cur_start_r, cur_start_nxt;
  logic signed [END_W-1:0] cur_end_r, cur_end_nxt;
  logic [IDX_W-1:0]        ins_reg_r, ins_reg_nxt;
  logic [IDX_W-1:0]        ins_k_r, ins_k_nxt;

  logic                got_r, got_nxt;
  logic [AREG_W-1:0]   areg_r, areg_nxt;
  logic                self_r, self_nxt;
  logic                evv_r, evv_nxt;
  logic [ID_WIDTH-1:0] evid_r, evid_nxt;

  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] km1_idx;
  logic [IDX_W-1:0] lowest_idx;

  logic signed [END_W:0] cmp_a, cmp_b;
  logic                  cmp_lt;

  logic shift_down, move_up, write_new;

  assign last_idx = IDX_W'(cnt_r - 1'b1);
  assign km1_idx  = ins_k_r - 1'b1;

  always_comb begin
    lowest_idx = '0;
    for (int i = NUM_REGS - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        lowest_idx = IDX_W'(i);
      end
    end
  end

  // shared end comparator: cmp_lt = a < b, signed
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state_r)
      S_EXPIRE: begin
        cmp_a = {ent_end_r[0][END_W-1], ent_end_r[0]};
        cmp_b = {2'b00, cur_start_r};
      end
      S_ALLOC: begin
        cmp_a = {cur_end_r[END_W-1], cur_end_r};
        cmp_b = {ent_end_r[last_idx][END_W-1], ent_end_r[last_idx]};
      end
      S_INSERT: begin
        cmp_a = {cur_end_r[END_W-1], cur_end_r};
        cmp_b = {ent_end_r[km1_idx][END_W-1], ent_end_r[km1_idx]};
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  assign cmp_lt = cmp_a < cmp_b;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    free_nxt       = free_r;
    failed_nxt     = failed_r;
    cur_id_nxt     = cur_id_r;
    cur_start_nxt  = cur_start_r;
    cur_end_nxt    = cur_end_r;
    ins_reg_nxt    = ins_reg_r;
    ins_k_nxt      = ins_k_r;
    got_nxt        = got_r;
    areg_nxt       = areg_r;
    self_nxt       = self_r;
    evv_nxt        = evv_r;
    evid_nxt       = evid_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    shift_down     = 1'b0;
    move_up        = 1'b0;
    write_new      = 1'b0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cur_id_nxt    = in_tdata[ID_WIDTH-1:0];
          cur_start_nxt = in_tdata[ID_WIDTH +: POS_WIDTH];
          cur_end_nxt   = in_tdata[ID_WIDTH+POS_WIDTH +: END_W];
          got_nxt       = 1'b0;
          areg_nxt      = '0;
          self_nxt      = 1'b0;
          evv_nxt       = 1'b0;
          evid_nxt      = '0;
          if (in_tuser) begin
            cnt_nxt    = '0;
            free_nxt   = '1;
            failed_nxt = 1'b0;
          end
          state_nxt = S_EXPIRE;
        end
      end
      S_EXPIRE: begin
        // one head entry checked per cycle
        if (cnt_r != '0 && cmp_lt) begin
          free_nxt[ent_reg_r[0]] = 1'b1;
          cnt_nxt    = cnt_r - 1'b1;
          shift_down = 1'b1;
        end else begin
          state_nxt = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (free_r != '0) begin
          free_nxt[lowest_idx] = 1'b0;
          ins_reg_nxt = lowest_idx;
          ins_k_nxt   = IDX_W'(cnt_r);
          got_nxt     = 1'b1;
          areg_nxt    = AREG_W'(REG_BASE + int'(lowest_idx));
          state_nxt   = S_INSERT;
        end else if (cnt_r != '0 && cmp_lt) begin
          // evict the entry with the largest end and take its register
          ins_reg_nxt = ent_reg_r[last_idx];
          ins_k_nxt   = last_idx;
          cnt_nxt     = cnt_r - 1'b1;
          evv_nxt     = 1'b1;
          evid_nxt    = ent_id_r[last_idx];
          failed_nxt  = 1'b1;
          got_nxt     = 1'b1;
          areg_nxt    = AREG_W'(REG_BASE + int'(ent_reg_r[last_idx]));
          state_nxt   = S_INSERT;
        end else begin
          self_nxt   = 1'b1;
          failed_nxt = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_INSERT: begin
        // walk from the tail; equal ends stay ahead of the new entry
        if (ins_k_r != '0 && cmp_lt) begin
          move_up   = 1'b1;
          ins_k_nxt = km1_idx;
        end else begin
          write_new = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_DATA_W'({failed_r, evid_r, evv_r, self_r, areg_r, got_r});
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      free_r       <= '1;
      failed_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      free_r       <= free_nxt;
      failed_r     <= failed_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    cur_id_r    <= cur_id_nxt;
    cur_start_r <= cur_start_nxt;
    cur_end_r   <= cur_end_nxt;
    ins_reg_r   <= ins_reg_nxt;
    ins_k_r     <= ins_k_nxt;
    got_r       <= got_nxt;
    areg_r      <= areg_nxt;
    self_r      <= self_nxt;
    evv_r       <= evv_nxt;
    evid_r      <= evid_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  always_ff @(posedge clk) begin
    if (shift_down) begin
      for (int i = 0; i < NUM_REGS - 1; i++) begin
        ent_end_r[i] <= ent_end_r[i+1];
        ent_id_r[i]  <= ent_id_r[i+1];
        ent_reg_r[i] <= ent_reg_r[i+1];
      end
    end
    if (move_up) begin
      ent_end_r[ins_k_r] <= ent_end_r[km1_idx];
      ent_id_r[ins_k_r]  <= ent_id_r[km1_idx];
      ent_reg_r[ins_k_r] <= ent_reg_r[km1_idx];
    end
    if (write_new) begin
      ent_end_r[ins_k_r] <= cur_end_r;
      ent_id_r[ins_k_r]  <= cur_id_r;
      ent_reg_r[ins_k_r] <= ins_reg_r;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

>>> bench/linear_scan_register_allocator_tb.sv
`timescale 1ns / 1ps

module linear_scan_register_allocator_tb;
  import lsra_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int DRAIN_CYCLES = 5 + 2 * NUM_REGS + 20;

  // receiver stall patterns
  localparam int RX_OPEN   = 0;
  localparam int RX_HALF   = 1;
  localparam int RX_CHOKED = 2;
  localparam int RX_MOSTLY = 3;

  typedef struct packed {
    logic                got;
    logic [AREG_W-1:0]   areg;
    logic                spill_new;
    logic                ev_valid;
    logic [ID_WIDTH-1:0] ev_id;
    logic                failed;
  } alloc_result_t;

  typedef struct {
    logic                 np;
    logic [ID_WIDTH-1:0]  id;
    logic [POS_WIDTH-1:0] sp;
    logic [END_W-1:0]     ep;
    bit                   known;
    alloc_result_t        res;
  } interval_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // predictor copy of the allocator state
  int                  live_end [NUM_REGS];
  logic [ID_WIDTH-1:0] live_id  [NUM_REGS];
  int                  live_reg [NUM_REGS];
  int                  live_cnt;
  logic [NUM_REGS-1:0] free_regs;
  logic                spill_seen;

  alloc_result_t pending_results[$];
  interval_row_t dir_rows[$];
  int            err_count = 0;
  int            cycle_cnt = 0;
  int            burst_left = 0;
  int            rx_mode = RX_OPEN;
  int            rx_phase_left = 0;

  linear_scan_register_allocator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic void clear_alloc();
    live_cnt   = 0;
    free_regs  = '1;
    spill_seen = 1'b0;
  endfunction

  function automatic alloc_result_t res_of(logic got, logic [AREG_W-1:0] areg, logic self,
                                           logic evv, logic [ID_WIDTH-1:0] evid,
                                           logic failed);
    alloc_result_t r;
    r.got       = got;
    r.areg      = areg;
    r.spill_new = self;
    r.ev_valid  = evv;
    r.ev_id     = evid;
    r.failed    = failed;
    return r;
  endfunction

  function automatic void add_row(logic np, logic [ID_WIDTH-1:0] id, logic [POS_WIDTH-1:0] sp,
                                  logic [END_W-1:0] ep, bit known, alloc_result_t res);
    interval_row_t r;
    r.np    = np;
    r.id    = id;
    r.sp    = sp;
    r.ep    = ep;
    r.known = known;
    r.res   = res;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // sorted insert, equal ends go behind the existing ones
  function automatic void place_live(int e, logic [ID_WIDTH-1:0] id, int idx);
    int pos;
    pos = 0;
    while (pos < live_cnt && live_end[pos] <= e) pos++;
    for (int k = live_cnt; k > pos; k--) begin
      live_end[k] = live_end[k-1];
      live_id[k]  = live_id[k-1];
      live_reg[k] = live_reg[k-1];
    end
    live_end[pos] = e;
    live_id[pos]  = id;
    live_reg[pos] = idx;
    live_cnt++;
  endfunction

  function automatic alloc_result_t allocate_interval(logic np, logic [ID_WIDTH-1:0] id,
                                                      logic [POS_WIDTH-1:0] sp,
                                                      logic [END_W-1:0] ep);
    alloc_result_t r;
    int s;
    int e;
    int idx;
    int last;
    r = '0;
    s = int'(sp);
    e = $signed(ep);
    if (np) clear_alloc();
    while (live_cnt > 0 && live_end[0] < s) begin
      free_regs[live_reg[0]] = 1'b1;
      for (int k = 1; k < live_cnt; k++) begin
        live_end[k-1] = live_end[k];
        live_id[k-1]  = live_id[k];
        live_reg[k-1] = live_reg[k];
      end
      live_cnt--;
    end
    if (free_regs != '0) begin
      idx = 0;
      while (!free_regs[idx]) idx++;
      free_regs[idx] = 1'b0;
      place_live(e, id, idx);
      r.got  = 1'b1;
      r.areg = AREG_W'(REG_BASE + idx);
    end else if (live_cnt > 0 && live_end[live_cnt-1] > e) begin
      last       = live_cnt - 1;
      idx        = live_reg[last];
      r.ev_valid = 1'b1;
      r.ev_id    = live_id[last];
      live_cnt--;
      place_live(e, id, idx);
      spill_seen = 1'b1;
      r.got      = 1'b1;
      r.areg     = AREG_W'(REG_BASE + idx);
    end else begin
      r.spill_new = 1'b1;
      spill_seen  = 1'b1;
    end
    r.failed = spill_seen;
    return r;
  endfunction

  task automatic send_interval(input logic np, input logic [ID_WIDTH-1:0] id,
                               input logic [POS_WIDTH-1:0] sp, input logic [END_W-1:0] ep,
                               input bit known, input alloc_result_t typed);
    logic [IN_DATA_W-1:0] beat;
    alloc_result_t        pred;
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    beat = '0;
    beat[ID_WIDTH-1:0]                   = id;
    beat[ID_WIDTH +: POS_WIDTH]          = sp;
    beat[ID_WIDTH + POS_WIDTH +: END_W]  = ep;
    in_tdata  = beat;
    in_tuser  = np;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pred = allocate_interval(np, id, sp, ep);
    pending_results.insert(pending_results.size(), known ? typed : pred);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode       = $urandom_range(RX_OPEN, RX_MOSTLY);
      rx_phase_left = $urandom_range(10, 200);
    end else begin
      rx_phase_left--;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_HALF:   out_tready <= ($urandom_range(0, 1) == 1);
      RX_CHOKED: out_tready <= ($urandom_range(0, 7) == 0);
      default:   out_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    alloc_result_t act;
    alloc_result_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      act.got       = out_tdata[0];
      act.areg      = out_tdata[1 +: AREG_W];
      act.spill_new = out_tdata[AREG_W + 1];
      act.ev_valid  = out_tdata[AREG_W + 2];
      act.ev_id     = out_tdata[AREG_W + 3 +: ID_WIDTH];
      act.failed    = out_tdata[AREG_W + 3 + ID_WIDTH];
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", out_tdata);
        err_count++;
      end else begin
        exp = pending_results.pop_front();
        if (act.got != exp.got) begin
          $error("got_register: expected %0d, actual %0d", exp.got, act.got);
          err_count++;
        end
        if (act.areg != exp.areg) begin
          $error("assigned_reg: expected %0d, actual %0d", exp.areg, act.areg);
          err_count++;
        end
        if (act.spill_new != exp.spill_new) begin
          $error("spilled_self: expected %0d, actual %0d", exp.spill_new, act.spill_new);
          err_count++;
        end
        if (act.ev_valid != exp.ev_valid) begin
          $error("evicted_valid: expected %0d, actual %0d", exp.ev_valid, act.ev_valid);
          err_count++;
        end
        if (act.ev_id != exp.ev_id) begin
          $error("evicted_id: expected %0d, actual %0d", exp.ev_id, act.ev_id);
          err_count++;
        end
        if (act.failed != exp.failed) begin
          $error("pass_failed: expected %0d, actual %0d", exp.failed, act.failed);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int             n;
    int             pass_len;
    int             pos;
    int             len;
    int             endv;
    logic           np;
    interval_row_t  row;

    clear_alloc();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // fresh state, never-used end, then top of range expiring it
    add_row(1'b1, 10'd0, 16'd0, 17'h1FFFF, 1'b1, res_of(1'b1, 4'd4, 1'b0, 1'b0, 10'd0, 1'b0));
    add_row(1'b0, 10'd1023, 16'd65535, 17'd65535, 1'b1,
            res_of(1'b1, 4'd4, 1'b0, 1'b0, 10'd0, 1'b0));
    // fill the pool with equal ends
    add_row(1'b1, 10'd1, 16'd0, 17'd100, 1'b1, res_of(1'b1, 4'd4,  1'b0, 1'b0, 10'd0, 1'b0));
    add_row(1'b0, 10'd2, 16'd0, 17'd100, 1'b1, res_of(1'b1, 4'd5,  1'b0, 1'b0, 10'd0, 1'b0));
    add_row(1'b0, 10'd3, 16'd0, 17'd100, 1'b1, res_of(1'b1, 4'd6,  1'b0, 1'b0, 10'd0, 1'b0));
    add_row(1'b0, 10'd4, 16'd0, 17'd100, 1'b1, res_of(1'b1, 4'd7,  1'b0, 1'b0, 10'd0, 1'b0));
    add_row(1'b0, 10'd5, 16'd0, 17'd100, 1'b1, res_of(1'b1, 4'd8,  1'b0, 1'b0, 10'd0, 1'b0));
    add_row(1'b0, 10'd6, 16'd0, 17'd100, 1'b1, res_of(1'b1, 4'd9,  1'b0, 1'b0, 10'd0, 1'b0));
    add_row(1'b0, 10'd7, 16'd0, 17'd100, 1'b1, res_of(1'b1, 4'd10, 1'b0, 1'b0, 10'd0, 1'b0));
    // equal end on a full pool spills the newcomer
    add_row(1'b0, 10'd8, 16'd1, 17'd100, 1'b1, res_of(1'b0, 4'd0,  1'b1, 1'b0, 10'd0, 1'b1));
    // shorter newcomer evicts the last of the equal ends
    add_row(1'b0, 10'd9, 16'd2, 17'd50,  1'b1, res_of(1'b1, 4'd10, 1'b0, 1'b1, 10'd7, 1'b1));
    add_row(1'b0, 10'd10, 16'd3, 17'd200, 1'b1, res_of(1'b0, 4'd0, 1'b1, 1'b0, 10'd0, 1'b1));
    // new pass clears the sticky flag
    add_row(1'b1, 10'd11, 16'd0, 17'h1FFFF, 1'b1, res_of(1'b1, 4'd4, 1'b0, 1'b0, 10'd0, 1'b0));
    add_row(1'b0, 10'd12, 16'd0, 17'd0,     1'b1, res_of(1'b1, 4'd4, 1'b0, 1'b0, 10'd0, 1'b0));
    // unsorted starts and odd bit patterns, predictor only
    add_row(1'b0, 10'd13,   16'd500,   17'd600,   1'b0, '0);
    add_row(1'b0, 10'd14,   16'd10,    17'd20,    1'b0, '0);
    add_row(1'b0, 10'd15,   16'd65535, 17'h1FFFF, 1'b0, '0);
    add_row(1'b0, 10'h2AA,  16'h5555,  17'h0AAAA, 1'b0, '0);
    add_row(1'b0, 10'h155,  16'hAAAA,  17'h15555, 1'b0, '0);
    add_row(1'b0, 10'd16,   16'd0,     17'd65535, 1'b0, '0);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_interval(row.np, row.id, row.sp, row.ep, row.known, row.res);
    end

    n = 0;
    while (n < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_interval(($urandom_range(0, 15) == 0), ID_WIDTH'($urandom), POS_WIDTH'($urandom),
                      END_W'($urandom), 1'b0, '0);
        n++;
      end else begin
        pass_len = $urandom_range(4, 60);
        pos = ($urandom_range(0, 7) == 0) ? $urandom_range(65000, 65535)
                                          : $urandom_range(0, 60000);
        for (int j = 0; j < pass_len && n < RANDOM_ITEMS; j++) begin
          pos += $urandom_range(0, 3);
          if (pos > 65535) pos = 65535;
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) * 8 : $urandom_range(0, 40);
          endv = ($urandom_range(0, 11) == 0) ? -1 : pos + len;
          if (endv > 65535) endv = 65535;
          // a pass now and then runs on without its opening flag
          np = (j == 0) && ($urandom_range(0, 3) != 0);
          send_interval(np, ID_WIDTH'($urandom), POS_WIDTH'(pos), END_W'(endv), 1'b0, '0);
          n++;
          if (n == RANDOM_ITEMS / 2) begin
            drain_results();
            repeat (DRAIN_CYCLES) @(negedge clk);
          end
        end
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
